/* sv/jte_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jte_pkg
// Shared types, codes and header tables for the JFIF thumbnail extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package jte_pkg;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_PIXELS = 2'd1,
		PH_ENDED  = 2'd2
	} phase_t;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_PIXEL  = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	localparam logic [2:0] ERR_MARKER  = 3'd0;
	localparam logic [2:0] ERR_IDENT   = 3'd1;
	localparam logic [2:0] ERR_VERSION = 3'd2;
	localparam logic [2:0] ERR_UNITS   = 3'd3;
	localparam logic [2:0] ERR_DENSITY = 3'd4;
	localparam logic [2:0] ERR_EMPTY   = 3'd5;
	localparam logic [2:0] ERR_TRUNC   = 3'd6;

	// header byte positions
	localparam logic [4:0] POS_LEN_HI   = 5'd4;
	localparam logic [4:0] POS_LEN_LO   = 5'd5;
	localparam logic [4:0] POS_FIXED    = 5'd13;
	localparam logic [4:0] POS_UNITS    = 5'd13;
	localparam logic [4:0] POS_XDEN_HI  = 5'd14;
	localparam logic [4:0] POS_XDEN_LO  = 5'd15;
	localparam logic [4:0] POS_YDEN_HI  = 5'd16;
	localparam logic [4:0] POS_YDEN_LO  = 5'd17;
	localparam logic [4:0] POS_WIDTH    = 5'd18;

	localparam logic [7:0] MAX_UNITS    = 8'd2;
	localparam logic [7:0] ALPHA_BYTE   = 8'hFF;

	// result queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] pixel_byte;
		logic [7:0] thumb_width;
		logic [7:0] thumb_height;
		logic [2:0] error_code;
		logic       last_of_image;
	} jte_res_t;

	typedef struct packed {
		logic [1:0] count;
		jte_res_t   first;
		jte_res_t   second;
	} jte_push_t;

	// SOI, APP0, length (unchecked), "JFIF\0", version 1.02
	function automatic logic [7:0] want_byte(input logic [3:0] pos);
		logic [7:0] v;
		unique case (pos)
			4'd0:    v = 8'hFF;
			4'd1:    v = 8'hD8;
			4'd2:    v = 8'hFF;
			4'd3:    v = 8'hE0;
			4'd6:    v = 8'h4A;
			4'd7:    v = 8'h46;
			4'd8:    v = 8'h49;
			4'd9:    v = 8'h46;
			4'd10:   v = 8'h00;
			4'd11:   v = 8'h01;
			4'd12:   v = 8'h02;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	function automatic logic [2:0] want_err(input logic [3:0] pos);
		logic [2:0] e;
		unique case (pos)
			4'd0, 4'd1, 4'd2, 4'd3:         e = ERR_MARKER;
			4'd6, 4'd7, 4'd8, 4'd9, 4'd10:  e = ERR_IDENT;
			4'd11, 4'd12:                   e = ERR_VERSION;
			default:                        e = ERR_MARKER;
		endcase
		return e;
	endfunction

endpackage

`default_nettype wire

/* sv/jte_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jte_parser
// Header parser and pixel pass-through state; one byte per step, up to two
// results per step.
// ----------------------------------------------------------------------------
`default_nettype none

module jte_parser (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step_en,
	input  wire logic               op,
	input  wire logic [7:0]         data_byte,
	output jte_pkg::jte_push_t      push
);
	import jte_pkg::*;

	phase_t      phase_q, phase_nxt;
	logic [4:0]  hdr_pos_q, hdr_pos_nxt;
	logic        hi_nz_q, hi_nz_nxt;
	logic [7:0]  width_q, width_nxt;
	logic [15:0] pix_left_q, pix_left_nxt;
	logic [1:0]  comp_q, comp_nxt;
	jte_push_t   res;

	always_comb begin
		phase_nxt    = phase_q;
		hdr_pos_nxt  = hdr_pos_q;
		hi_nz_nxt    = hi_nz_q;
		width_nxt    = width_q;
		pix_left_nxt = pix_left_q;
		comp_nxt     = comp_q;
		res          = '0;
		if (op) begin
			if (phase_q != PH_ENDED) begin
				res.count            = 2'd1;
				res.first.kind       = KIND_ERROR;
				res.first.error_code = ERR_TRUNC;
			end
			phase_nxt    = PH_HEADER;
			hdr_pos_nxt  = '0;
			hi_nz_nxt    = 1'b0;
			width_nxt    = '0;
			pix_left_nxt = '0;
			comp_nxt     = '0;
		end else begin
			unique case (phase_q)
				PH_PIXELS: begin
					res.count            = 2'd1;
					res.first.kind       = KIND_PIXEL;
					res.first.pixel_byte = data_byte;
					if (comp_q >= 2'd2) begin
						// blue byte: append alpha
						comp_nxt                 = '0;
						pix_left_nxt             = 16'(pix_left_q - 16'd1);
						res.count                = 2'd2;
						res.second.kind          = KIND_PIXEL;
						res.second.pixel_byte    = ALPHA_BYTE;
						res.second.last_of_image = (pix_left_q == 16'd1);
						if (pix_left_q == 16'd1)
							phase_nxt = PH_ENDED;
					end else begin
						comp_nxt = 2'(comp_q + 2'd1);
					end
				end
				PH_HEADER: begin
					hdr_pos_nxt = 5'(hdr_pos_q + 5'd1);
					if (hdr_pos_q < POS_FIXED) begin
						if (hdr_pos_q != POS_LEN_HI && hdr_pos_q != POS_LEN_LO &&
								data_byte != want_byte(hdr_pos_q[3:0])) begin
							res.count            = 2'd1;
							res.first.kind       = KIND_ERROR;
							res.first.error_code = want_err(hdr_pos_q[3:0]);
							phase_nxt            = PH_ENDED;
							hdr_pos_nxt          = hdr_pos_q;
						end
					end else if (hdr_pos_q == POS_UNITS) begin
						if (data_byte > MAX_UNITS) begin
							res.count            = 2'd1;
							res.first.kind       = KIND_ERROR;
							res.first.error_code = ERR_UNITS;
							phase_nxt            = PH_ENDED;
							hdr_pos_nxt          = hdr_pos_q;
						end
					end else if (hdr_pos_q == POS_XDEN_HI || hdr_pos_q == POS_YDEN_HI) begin
						hi_nz_nxt = (data_byte != 8'd0);
					end else if (hdr_pos_q == POS_XDEN_LO || hdr_pos_q == POS_YDEN_LO) begin
						if (!hi_nz_q && data_byte == 8'd0) begin
							res.count            = 2'd1;
							res.first.kind       = KIND_ERROR;
							res.first.error_code = ERR_DENSITY;
							phase_nxt            = PH_ENDED;
							hdr_pos_nxt          = hdr_pos_q;
						end
					end else if (hdr_pos_q == POS_WIDTH) begin
						width_nxt = data_byte;
					end else begin
						if (width_q == 8'd0 || data_byte == 8'd0) begin
							res.count            = 2'd1;
							res.first.kind       = KIND_ERROR;
							res.first.error_code = ERR_EMPTY;
							phase_nxt            = PH_ENDED;
							hdr_pos_nxt          = hdr_pos_q;
						end else begin
							// count pixels rather than bytes: one decrement per blue byte
							pix_left_nxt           = {8'd0, width_q} * {8'd0, data_byte};
							comp_nxt               = '0;
							phase_nxt              = PH_PIXELS;
							hdr_pos_nxt            = '0;
							res.count              = 2'd1;
							res.first.kind         = KIND_HEADER;
							res.first.thumb_width  = width_q;
							res.first.thumb_height = data_byte;
						end
					end
				end
				default: begin
					// ended: data bytes are dropped until end of stream
				end
			endcase
		end
	end

	always_comb begin
		push       = res;
		push.count = step_en ? res.count : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			hdr_pos_q  <= '0;
			hi_nz_q    <= 1'b0;
			width_q    <= '0;
			pix_left_q <= '0;
			comp_q     <= '0;
		end else if (step_en) begin
			phase_q    <= phase_nxt;
			hdr_pos_q  <= hdr_pos_nxt;
			hi_nz_q    <= hi_nz_nxt;
			width_q    <= width_nxt;
			pix_left_q <= pix_left_nxt;
			comp_q     <= comp_nxt;
		end
	end

endmodule

`default_nettype wire

/* sv/jte_res_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jte_res_fifo
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module jte_res_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire jte_pkg::jte_push_t push,
	output logic                    room,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output jte_pkg::jte_res_t       head
);
	import jte_pkg::*;

	jte_res_t             mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_CW-1:0]   count_q;
	logic                 pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign head      = mem[rd_ptr_q];
	assign room      = (count_q <= FIFO_CW'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			mem[wr_ptr_q] <= push.first;
		if (push.count == 2'd2)
			mem[FIFO_AW'(wr_ptr_q + FIFO_AW'(1))] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= FIFO_AW'(wr_ptr_q + FIFO_AW'(push.count));
			rd_ptr_q <= FIFO_AW'(rd_ptr_q + FIFO_AW'(pop));
			count_q  <= FIFO_CW'(count_q + FIFO_CW'(push.count) - FIFO_CW'(pop));
		end
	end

endmodule

`default_nettype wire

/* sv/jfif_thumbnail_extractor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfif_thumbnail_extractor
// Parses a JFIF APP0 header from a byte stream and emits the embedded RGB
// thumbnail as RGBA bytes.
// ----------------------------------------------------------------------------
// Input request: op (0 data byte, 1 end of stream) and data_byte, on
// in_valid/in_ready. Output request: kind, pixel_byte, thumb_width,
// thumb_height, error_code, last_of_image, on out_valid/out_ready.
// A blue byte gives two requests (blue and alpha), so pixel data drains at
// four output requests per three input bytes, set by the output port, which
// hands out one request per cycle while out_ready is high.
// Path: a request is held in the input register, then the parser steps on it
// and writes its results into a four-entry result queue, whose head drives
// the output ports.
// The parser steps only while the queue has room for two results; a stalled
// receiver fills the queue and then holds in_ready low. The input register
// keeps accepting while a result waits at the output and the queue has room.
// Reset clears the parser to the start of the header and empties the queue;
// no result is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module jfif_thumbnail_extractor (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       op,
	input  wire logic [7:0] data_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      kind,
	output logic [7:0]      pixel_byte,
	output logic [7:0]      thumb_width,
	output logic [7:0]      thumb_height,
	output logic [2:0]      error_code,
	output logic            last_of_image
);
	import jte_pkg::*;

	logic       valid_s1;
	logic       op_s1;
	logic [7:0] data_s1;
	logic       room;
	logic       step;
	jte_push_t  push;
	jte_res_t   head;

	assign step     = valid_s1 && room;
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= op;
			data_s1 <= data_byte;
		end
	end

	jte_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (step),
		.op        (op_s1),
		.data_byte (data_s1),
		.push      (push)
	);

	jte_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign kind          = head.kind;
	assign pixel_byte    = head.pixel_byte;
	assign thumb_width   = head.thumb_width;
	assign thumb_height  = head.thumb_height;
	assign error_code    = head.error_code;
	assign last_of_image = head.last_of_image;

endmodule

`default_nettype wire

/* sv/jte_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jte_checker
// Port-level checks on the result channel of the thumbnail extractor.
// ----------------------------------------------------------------------------
`default_nettype none

module jte_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       out_valid,
	input  wire logic       out_ready,
	input  wire logic [1:0] kind,
	input  wire logic [7:0] pixel_byte,
	input  wire logic [7:0] thumb_width,
	input  wire logic [7:0] thumb_height,
	input  wire logic [2:0] error_code,
	input  wire logic       last_of_image
);
	import jte_pkg::*;

	// a stalled request holds its kind, pixel byte, error code and end flag
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(pixel_byte)
			&& $stable(last_of_image) && $stable(error_code))
		else $error("stalled result changed");

	// end of image only ever on an alpha byte
	a_last_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_image |-> kind == KIND_PIXEL && pixel_byte == ALPHA_BYTE)
		else $error("last_of_image on a non-alpha byte");

	// header info only after both dimensions passed the empty check
	a_hdr_dims: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_HEADER |-> thumb_width != 8'd0 && thumb_height != 8'd0
			&& error_code == 3'd0 && pixel_byte == 8'd0)
		else $error("header result with empty dimensions");

	// error results carry only a code
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ERROR |-> pixel_byte == 8'd0 && thumb_width == 8'd0
			&& thumb_height == 8'd0 && !last_of_image)
		else $error("error result carries payload");

endmodule

bind jfif_thumbnail_extractor jte_checker u_jte_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.kind          (kind),
	.pixel_byte    (pixel_byte),
	.thumb_width   (thumb_width),
	.thumb_height  (thumb_height),
	.error_code    (error_code),
	.last_of_image (last_of_image)
);

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the JFIF thumbnail extractor.
// Streams directed and random byte sequences into the block: good images,
// damaged headers, streams cut short and noise. Both sides stall at random,
// and the receiver holds off once for a long stretch. Every result is checked
// against a behavioural parser model, in order.
// ----------------------------------------------------------------------------

module tb_top;
	import jte_pkg::*;

	localparam int LIMIT        = 400000;
	localparam int RANDOM_ITEMS = 1050;
	localparam int TAIL_ITEMS   = 120;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN        = 16;
	localparam int REPORT_MAX   = 60;
	localparam int HDR_LEN      = 20;

	// header byte positions
	localparam int P_LEN_HI  = 4;
	localparam int P_LEN_LO  = 5;
	localparam int P_UNITS   = 13;
	localparam int P_XDEN_HI = 14;
	localparam int P_XDEN_LO = 15;
	localparam int P_YDEN_HI = 16;
	localparam int P_YDEN_LO = 17;
	localparam int P_WIDTH   = 18;
	localparam int P_HEIGHT  = 19;

	typedef struct packed {
		logic       is_end;
		logic [7:0] value;
	} byte_req_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       op = 1'b0;
	logic [7:0] data_byte = 8'h00;
	logic       out_ready = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic [1:0] kind;
	logic [7:0] pixel_byte;
	logic [7:0] thumb_width;
	logic [7:0] thumb_height;
	logic [2:0] error_code;
	logic       last_of_image;

	jfif_thumbnail_extractor dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.data_byte     (data_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.pixel_byte    (pixel_byte),
		.thumb_width   (thumb_width),
		.thumb_height  (thumb_height),
		.error_code    (error_code),
		.last_of_image (last_of_image)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	byte_req_t  pending [$];
	jte_res_t   expected_res [$];

	// fixed header signature and the error each position raises
	logic [7:0] sig_byte [0:12];
	logic [2:0] sig_err [0:12];
	logic [7:0] hdr_buf [0:HDR_LEN-1];

	// parser model state
	logic [4:0]  m_pos;
	logic        m_hi_nz;
	logic [7:0]  m_width;
	logic [7:0]  m_height;
	logic [17:0] m_left;
	logic [1:0]  m_comp;
	phase_t      m_phase;

	int mismatches = 0;
	int n_req = 0;
	int n_hdr = 0;
	int n_pix = 0;
	int n_err = 0;
	int n_last = 0;
	logic [6:0] err_seen = '0;
	int cycle_count = 0;

	function automatic jte_res_t make_res(input logic [1:0] k, input logic [7:0] pix,
			input logic [7:0] w, input logic [7:0] h, input logic [2:0] e, input logic last);
		jte_res_t r;
		r.kind = k;
		r.pixel_byte = pix;
		r.thumb_width = w;
		r.thumb_height = h;
		r.error_code = e;
		r.last_of_image = last;
		return r;
	endfunction

	task automatic expect_res(input jte_res_t r);
		expected_res = {expected_res, r};
	endtask

	task automatic parser_restart;
		m_pos = '0;
		m_hi_nz = 1'b0;
		m_width = '0;
		m_height = '0;
		m_left = '0;
		m_comp = '0;
		m_phase = PH_HEADER;
	endtask

	task automatic parser_fail(input logic [2:0] code);
		expect_res(make_res(KIND_ERROR, 8'h00, 8'h00, 8'h00, code, 1'b0));
		m_phase = PH_ENDED;
	endtask

	task automatic parser_step(input logic is_end, input logic [7:0] b);
		int area;
		if (is_end) begin
			if (m_phase != PH_ENDED)
				parser_fail(ERR_TRUNC);
			parser_restart();
			return;
		end
		if (m_phase == PH_PIXELS) begin
			expect_res(make_res(KIND_PIXEL, b, 8'h00, 8'h00, 3'd0, 1'b0));
			m_left = m_left - 18'd1;
			if (m_comp >= 2'd2) begin
				// blue byte: alpha follows
				m_comp = '0;
				expect_res(make_res(KIND_PIXEL, ALPHA_BYTE, 8'h00, 8'h00, 3'd0,
					m_left == 18'd0));
				if (m_left == 18'd0)
					m_phase = PH_ENDED;
			end else begin
				m_comp = m_comp + 2'd1;
			end
			return;
		end
		if (m_phase != PH_HEADER)
			return;
		if (m_pos < P_UNITS) begin
			if (m_pos != P_LEN_HI && m_pos != P_LEN_LO && b != sig_byte[m_pos]) begin
				parser_fail(sig_err[m_pos]);
				return;
			end
		end else if (m_pos == P_UNITS) begin
			if (b > MAX_UNITS) begin
				parser_fail(ERR_UNITS);
				return;
			end
		end else if (m_pos == P_XDEN_HI || m_pos == P_YDEN_HI) begin
			m_hi_nz = (b != 8'h00);
		end else if (m_pos == P_XDEN_LO || m_pos == P_YDEN_LO) begin
			if (!m_hi_nz && b == 8'h00) begin
				parser_fail(ERR_DENSITY);
				return;
			end
		end else if (m_pos == P_WIDTH) begin
			m_width = b;
		end else begin
			m_height = b;
			if (m_width == 8'h00 || m_height == 8'h00) begin
				parser_fail(ERR_EMPTY);
				return;
			end
			area = m_width * m_height * 3;
			m_left = area[17:0];
			m_comp = '0;
			m_phase = PH_PIXELS;
			m_pos = '0;
			expect_res(make_res(KIND_HEADER, 8'h00, m_width, m_height, 3'd0, 1'b0));
			return;
		end
		m_pos = m_pos + 5'd1;
	endtask

	task automatic put_byte(input logic [7:0] b);
		byte_req_t r;
		r.is_end = 1'b0;
		r.value = b;
		pending = {pending, r};
	endtask

	task automatic put_end;
		byte_req_t r;
		r.is_end = 1'b1;
		r.value = 8'($urandom_range(0, 255));
		pending = {pending, r};
	endtask

	task automatic fill_header(input logic [7:0] w, input logic [7:0] h);
		int i;
		for (i = 0; i < P_UNITS; i++)
			hdr_buf[i] = sig_byte[i];
		hdr_buf[P_LEN_HI] = 8'($urandom_range(0, 255));
		hdr_buf[P_LEN_LO] = 8'($urandom_range(0, 255));
		hdr_buf[P_UNITS] = 8'($urandom_range(0, 2));
		for (i = P_XDEN_HI; i <= P_YDEN_HI; i += 2) begin
			case ($urandom_range(0, 2))
				0: begin
					hdr_buf[i] = 8'h00;
					hdr_buf[i+1] = 8'($urandom_range(1, 255));
				end
				1: begin
					hdr_buf[i] = 8'($urandom_range(1, 255));
					hdr_buf[i+1] = 8'h00;
				end
				default: begin
					hdr_buf[i] = 8'($urandom_range(1, 255));
					hdr_buf[i+1] = 8'($urandom_range(0, 255));
				end
			endcase
		end
		hdr_buf[P_WIDTH] = w;
		hdr_buf[P_HEIGHT] = h;
	endtask

	task automatic put_header_upto(input int n);
		int i;
		for (i = 0; i < n; i++)
			put_byte(hdr_buf[i]);
	endtask

	task automatic put_pixels(input int n);
		repeat (n) put_byte(8'($urandom_range(0, 255)));
	endtask

	// one random image, always closed by an end of stream
	task automatic put_image;
		int sel;
		int total;
		int cut;
		int pos;
		logic [7:0] w;
		logic [7:0] h;
		sel = $urandom_range(0, 99);
		if (sel < 55) begin
			if ($urandom_range(0, 6) == 0) begin
				// thumbnail of up to 255x255: header, then up to 24 pixel bytes before the end
				w = 8'($urandom_range(1, 255));
				h = 8'($urandom_range(1, 255));
				if ($urandom_range(0, 2) == 0) begin
					w = 8'hFF;
					h = 8'hFF;
				end
				total = w * h * 3;
				cut = $urandom_range(0, 24);
			end else begin
				w = 8'($urandom_range(1, 4));
				h = 8'($urandom_range(1, 4));
				total = w * h * 3;
				cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, total - 1) : total;
			end
			fill_header(w, h);
			put_header_upto(HDR_LEN);
			put_pixels(cut);
			if (cut == total)
				repeat ($urandom_range(0, 2)) put_byte(8'($urandom_range(0, 255)));
			put_end();
		end else if (sel < 80) begin
			fill_header(8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)));
			pos = $urandom_range(0, HDR_LEN - 3);
			if (pos >= P_LEN_HI)
				pos += 2;
			case (pos)
				P_UNITS:
					hdr_buf[pos] = 8'($urandom_range(3, 255));
				P_XDEN_HI, P_XDEN_LO: begin
					hdr_buf[P_XDEN_HI] = 8'h00;
					hdr_buf[P_XDEN_LO] = 8'h00;
				end
				P_YDEN_HI, P_YDEN_LO: begin
					hdr_buf[P_YDEN_HI] = 8'h00;
					hdr_buf[P_YDEN_LO] = 8'h00;
				end
				P_WIDTH: begin
					hdr_buf[P_WIDTH] = 8'h00;
					hdr_buf[P_HEIGHT] = 8'($urandom_range(0, 255));
				end
				P_HEIGHT: begin
					hdr_buf[P_WIDTH] = 8'($urandom_range(0, 255));
					hdr_buf[P_HEIGHT] = 8'h00;
				end
				default:
					hdr_buf[pos] = hdr_buf[pos] ^ 8'($urandom_range(1, 255));
			endcase
			put_header_upto(HDR_LEN);
			put_pixels($urandom_range(0, 3));
			put_end();
		end else if (sel < 92) begin
			fill_header(8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)));
			put_header_upto($urandom_range(0, HDR_LEN - 1));
			put_end();
		end else begin
			repeat ($urandom_range(1, 6)) begin
				if ($urandom_range(0, 3) == 0)
					put_end();
				else
					put_byte(8'($urandom_range(0, 255)));
			end
			put_end();
		end
	endtask

	// request driver
	byte_req_t next_req;
	int tx_gap = 0;
	int tx_cycles = 0;
	logic tx_quiet;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			op <= 1'b0;
			data_byte <= 8'h00;
			tx_gap = 0;
			tx_cycles = 0;
		end else begin
			tx_cycles = tx_cycles + 1;
			tx_quiet = (pending.size() < TAIL_ITEMS) || ((tx_cycles / 150) % 4 == 3);
			if (!in_valid || in_ready) begin
				if (tx_gap != 0) begin
					tx_gap = tx_gap - 1;
					in_valid <= 1'b0;
				end else if (pending.size() != 0) begin
					next_req = pending.pop_front();
					in_valid <= 1'b1;
					op <= next_req.is_end;
					data_byte <= next_req.value;
					if (!tx_quiet && $urandom_range(0, 11) == 0)
						tx_gap = $urandom_range(1, 14);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls plus one long hold to back the block up
	int rx_stall = 0;
	int rx_cycles = 0;
	logic rx_quiet;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_stall = 0;
			rx_cycles = 0;
		end else begin
			rx_cycles = rx_cycles + 1;
			rx_quiet = (pending.size() < TAIL_ITEMS) || ((rx_cycles / 180) % 4 == 1);
			if (rx_cycles >= HOLD_AT && rx_cycles < HOLD_AT + HOLD_CYCLES) begin
				out_ready <= 1'b0;
			end else if (rx_stall != 0) begin
				rx_stall = rx_stall - 1;
				out_ready <= 1'b0;
			end else if (!rx_quiet && $urandom_range(0, 9) == 0) begin
				rx_stall = $urandom_range(0, 13);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic report_field(input string field, input logic [7:0] want_v,
			input logic [7:0] got_v);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$error("%s mismatch: expected %0d, got %0d", field, want_v, got_v);
	endtask

	// monitor: check the outgoing request first, then predict from the incoming one
	jte_res_t want;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_res.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$error("unexpected result: kind %0d pixel %0d err %0d", kind, pixel_byte,
							error_code);
				end else begin
					want = expected_res.pop_front();
					if (kind !== want.kind)
						report_field("kind", 8'(want.kind), 8'(kind));
					if (pixel_byte !== want.pixel_byte)
						report_field("pixel_byte", want.pixel_byte, pixel_byte);
					if (thumb_width !== want.thumb_width)
						report_field("thumb_width", want.thumb_width, thumb_width);
					if (thumb_height !== want.thumb_height)
						report_field("thumb_height", want.thumb_height, thumb_height);
					if (error_code !== want.error_code)
						report_field("error_code", 8'(want.error_code), 8'(error_code));
					if (last_of_image !== want.last_of_image)
						report_field("last_of_image", 8'(want.last_of_image),
							8'(last_of_image));
					case (want.kind)
						KIND_HEADER: n_hdr++;
						KIND_PIXEL:  n_pix++;
						default: begin
							n_err++;
							err_seen[want.error_code] = 1'b1;
						end
					endcase
					if (want.last_of_image)
						n_last++;
				end
			end
			if (in_valid && in_ready) begin
				n_req++;
				parser_step(op, data_byte);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_res.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		sig_byte[0] = 8'hFF;  sig_err[0] = ERR_MARKER;
		sig_byte[1] = 8'hD8;  sig_err[1] = ERR_MARKER;
		sig_byte[2] = 8'hFF;  sig_err[2] = ERR_MARKER;
		sig_byte[3] = 8'hE0;  sig_err[3] = ERR_MARKER;
		sig_byte[4] = 8'h00;  sig_err[4] = ERR_MARKER;
		sig_byte[5] = 8'h00;  sig_err[5] = ERR_MARKER;
		sig_byte[6] = 8'h4A;  sig_err[6] = ERR_IDENT;
		sig_byte[7] = 8'h46;  sig_err[7] = ERR_IDENT;
		sig_byte[8] = 8'h49;  sig_err[8] = ERR_IDENT;
		sig_byte[9] = 8'h46;  sig_err[9] = ERR_IDENT;
		sig_byte[10] = 8'h00; sig_err[10] = ERR_IDENT;
		sig_byte[11] = 8'h01; sig_err[11] = ERR_VERSION;
		sig_byte[12] = 8'h02; sig_err[12] = ERR_VERSION;
		parser_restart();

		// directed: empty stream, bad first byte, bytes and end after an
		// ended image, then a 1x1 thumbnail with the header fields at their top
		put_end();
		put_byte(8'h00);
		put_byte(8'hFF);
		put_end();
		fill_header(8'd1, 8'd1);
		hdr_buf[P_LEN_HI] = 8'hFF;
		hdr_buf[P_LEN_LO] = 8'hFF;
		hdr_buf[P_UNITS] = MAX_UNITS;
		hdr_buf[P_XDEN_HI] = 8'hFF;
		hdr_buf[P_XDEN_LO] = 8'hFF;
		hdr_buf[P_YDEN_HI] = 8'hFF;
		hdr_buf[P_YDEN_LO] = 8'hFF;
		put_header_upto(HDR_LEN);
		put_byte(8'h00);
		put_byte(8'hFF);
		put_byte(8'h80);
		put_end();

		while (pending.size() < RANDOM_ITEMS + 28)
			put_image();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_res.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("%0d requests in, %0d headers, %0d pixel bytes, %0d images completed",
			n_req, n_hdr, n_pix, n_last);
		$display("%0d error results, error codes seen %b, %0d mismatches", n_err, err_seen,
			mismatches);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* jfif_thumbnail_extractor.f */
sv/jte_pkg.sv
sv/jte_parser.sv
sv/jte_res_fifo.sv
sv/jfif_thumbnail_extractor.sv
sv/jte_checker.sv
bench/tb_top.sv
